// ----- src/icr_four_wheel_steer_map_unit_defines.svh -----
// Assertion macros shared by the checker of the steering map unit.
`ifndef ICR_FOUR_WHEEL_STEER_MAP_UNIT_DEFINES_SVH
`define ICR_FOUR_WHEEL_STEER_MAP_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ICR4WS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ICR4WS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/icr4ws_pkg.sv -----
`default_nettype none
package icr4ws_pkg;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned CORDIC_STAGES = 16;

  localparam int unsigned IN_W    = 21;
  localparam int unsigned ANG_W   = 18;
  localparam int unsigned SPD_W   = 32;
  localparam int unsigned BASE_W  = 18;
  localparam int unsigned TRACK_W = 18;
  localparam int unsigned WRAD_W  = 16;
  localparam int unsigned LIM_W   = 17;
  localparam int unsigned CFG_W   = 18;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned RM_W    = 30;
  localparam int unsigned D_W     = 33;

  localparam logic [IDX_W-1:0] REG_WHEEL_BASE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WHEEL_TRACK  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WHEEL_RADIUS = 2'd2;
  localparam logic [IDX_W-1:0] REG_STEER_LIMIT  = 2'd3;

  localparam logic [BASE_W-1:0]  BASE_RST  = 18'd71434;
  localparam logic [TRACK_W-1:0] TRACK_RST = 18'd73794;
  localparam logic [WRAD_W-1:0]  WRAD_RST  = 16'd9830;
  localparam logic [LIM_W-1:0]   LIM_RST   = 17'd68629;

  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic            valid;
    logic            stop;
    logic            vneg;
    logic [IN_W-1:0] vmag;
    logic [RM_W-1:0] rm;
  } ctl_t;

  typedef struct packed {
    logic             valid;
    logic             stop;
    logic [ANG_W-1:0] steer_l;
    logic [ANG_W-1:0] steer_r;
    logic [SPD_W-1:0] speed_l;
    logic [SPD_W-1:0] speed_r;
  } res_t;

endpackage
`default_nettype wire

// ----- src/icr4ws_div.sv -----
`default_nettype none
module icr4ws_div #(
  parameter int unsigned N_W   = 36,
  parameter int unsigned DEN_W = 21,
  parameter int unsigned LANES = 1,
  parameter int unsigned SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [N_W-1:0]   num_i [LANES],
  input  logic [DEN_W-1:0] den_i [LANES],
  input  logic [DEN_W-1:0] rem_i [LANES],
  input  logic [SB_W-1:0]  sb_i,
  output logic [N_W-1:0]   q_o   [LANES],
  output logic [SB_W-1:0]  sb_o
);

  logic [N_W-1:0]   num_s [N_W+1][LANES];
  logic [DEN_W-1:0] den_s [N_W+1][LANES];
  logic [DEN_W-1:0] rem_s [N_W+1][LANES];
  logic [SB_W-1:0]  sb_s  [N_W+1];

  assign sb_s[0] = sb_i;
  assign sb_o    = sb_s[N_W];

  for (genvar l = 0; l < LANES; l++) begin : g_io
    assign num_s[0][l] = num_i[l];
    assign den_s[0][l] = den_i[l];
    assign rem_s[0][l] = rem_i[l];
    assign q_o[l]      = num_s[N_W][l];
  end

  for (genvar k = 0; k < N_W; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_s[k+1] <= '0;
      end else if (en_i) begin
        sb_s[k+1] <= sb_s[k];
      end
    end
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] trial;
      logic           ge;
      assign trial = {rem_s[k][l], num_s[k][l][N_W-1]};
      assign ge    = trial >= {1'b0, den_s[k][l]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_s[k+1][l] <= ge ? DEN_W'(trial - {1'b0, den_s[k][l]}) : trial[DEN_W-1:0];
          num_s[k+1][l] <= {num_s[k][l][N_W-2:0], ge};
          den_s[k+1][l] <= den_s[k][l];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/icr4ws_lanes.sv -----
`default_nettype none
module icr4ws_lanes #(
  parameter int unsigned FRAC_BITS     = icr4ws_pkg::FRAC_BITS,
  parameter int unsigned CORDIC_STAGES = icr4ws_pkg::CORDIC_STAGES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [icr4ws_pkg::BASE_W-1:0]       wheel_base_i,
  input  logic [icr4ws_pkg::WRAD_W-1:0]       wheel_radius_i,
  input  logic [icr4ws_pkg::LIM_W-1:0]        steer_limit_i,
  input  icr4ws_pkg::ctl_t                    ctl_i,
  input  logic signed [icr4ws_pkg::D_W-1:0]   d_i [2],
  output icr4ws_pkg::res_t                    res_o
);

  localparam int unsigned K    = 32;
  localparam int unsigned CW   = 36;
  localparam int unsigned SH   = 30 - FRAC_BITS;
  localparam int unsigned RW   = 32 + FRAC_BITS;
  localparam int unsigned H    = (RW + 1) / 2;
  localparam int unsigned HI_W = RW - H;
  localparam int unsigned VW   = icr4ws_pkg::IN_W;
  localparam int unsigned PW   = VW + RW;
  localparam int unsigned EXT_W = (PW > 64) ? PW : 65;
  localparam int unsigned AW   = icr4ws_pkg::ANG_W;
  localparam logic signed [32:0] RND = 33'sd1 <<< (SH - 1);

  typedef struct packed {
    logic          valid;
    logic          stop;
    logic          vneg;
    logic [VW-1:0] vmag;
    logic [AW-1:0] ang_l;
    logic [AW-1:0] ang_r;
  } rsb_t;

  typedef struct packed {
    logic          valid;
    logic          stop;
    logic          vneg;
    logic          big_l;
    logic          big_r;
    logic [AW-1:0] ang_l;
    logic [AW-1:0] ang_r;
  } ssb_t;

  // Magnitude, squares and the joint root / CORDIC stages.
  icr4ws_pkg::ctl_t ctl_a_q, ctl_b_q;
  icr4ws_pkg::ctl_t ctl_s [K+1];
  logic [31:0]            du_a_q [2], du_b_q [2];
  logic                   dn_a_q [2], dn_b_q [2];
  logic [63:0]            dsq_q  [2];
  logic [2*icr4ws_pkg::BASE_W-1:0] bsq_q;

  logic signed [CW-1:0] cx_s [K+1][2];
  logic signed [CW-1:0] cy_s [K+1][2];
  logic signed [31:0]   cz_s [K+1][2];
  logic [63:0]          rad_s [K+1][2];
  logic [33:0]          rem_s [K+1][2];
  logic [31:0]          root_s [K+1][2];
  logic                 dn_s [K+1][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q   <= '0;
      ctl_b_q   <= '0;
      ctl_s[0]  <= '0;
    end else if (en_i) begin
      ctl_a_q   <= ctl_i;
      ctl_b_q   <= ctl_a_q;
      ctl_s[0]  <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bsq_q <= wheel_base_i * wheel_base_i;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_front
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        du_a_q[l] <= d_i[l][icr4ws_pkg::D_W-1] ? 32'(-d_i[l]) : d_i[l][31:0];
        dn_a_q[l] <= d_i[l][icr4ws_pkg::D_W-1];
        du_b_q[l] <= du_a_q[l];
        dn_b_q[l] <= dn_a_q[l];
        dsq_q[l]  <= du_a_q[l] * du_a_q[l];
        rad_s[0][l]  <= dsq_q[l] + 64'(bsq_q);
        rem_s[0][l]  <= '0;
        root_s[0][l] <= '0;
        cx_s[0][l]   <= $signed({{(CW-32){1'b0}}, du_b_q[l]});
        cy_s[0][l]   <= $signed({{(CW-icr4ws_pkg::BASE_W){1'b0}}, wheel_base_i});
        cz_s[0][l]   <= '0;
        dn_s[0][l]   <= dn_b_q[l];
      end
    end
  end

  for (genvar k = 0; k < K; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_s[k+1] <= '0;
      end else if (en_i) begin
        ctl_s[k+1] <= ctl_s[k];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [35:0] trial;
      logic [35:0] sub;
      logic        ge;
      assign trial = {rem_s[k][l], rad_s[k][l][63:62]};
      assign sub   = {2'b00, root_s[k][l], 2'b01};
      assign ge    = trial >= sub;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_s[k+1][l]  <= ge ? 34'(trial - sub) : trial[33:0];
          root_s[k+1][l] <= {root_s[k][l][30:0], ge};
          rad_s[k+1][l]  <= {rad_s[k][l][61:0], 2'b00};
          dn_s[k+1][l]   <= dn_s[k][l];
        end
      end
      if (k < CORDIC_STAGES) begin : g_rot
        logic signed [CW-1:0] dx, dy;
        logic signed [31:0]   at;
        assign dx = cy_s[k][l] >>> k;
        assign dy = cx_s[k][l] >>> k;
        assign at = $signed(icr4ws_pkg::ATAN_Q30[k]);
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            if (cy_s[k][l] > 0) begin
              cx_s[k+1][l] <= cx_s[k][l] + dx;
              cy_s[k+1][l] <= cy_s[k][l] - dy;
              cz_s[k+1][l] <= cz_s[k][l] + at;
            end else begin
              cx_s[k+1][l] <= cx_s[k][l] - dx;
              cy_s[k+1][l] <= cy_s[k][l] + dy;
              cz_s[k+1][l] <= cz_s[k][l] - at;
            end
          end
        end
      end else begin : g_hold
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            cx_s[k+1][l] <= cx_s[k][l];
            cy_s[k+1][l] <= cy_s[k][l];
            cz_s[k+1][l] <= cz_s[k][l];
          end
        end
      end
    end
  end

  // Angle rounding and clamp, then ratio = (root << FRAC_BITS) / (2 |R|).
  localparam int unsigned RM_W_P = icr4ws_pkg::RM_W;
  logic [AW-1:0]   ang [2];
  logic [RW-1:0]   rnum [2];
  logic [RM_W_P:0] rden [2];
  logic [RM_W_P:0] rrem [2];
  logic [RW-1:0]   ratio [2];
  rsb_t            rsb_in, rsb_out;

  for (genvar l = 0; l < 2; l++) begin : g_ang
    logic signed [32:0] zr, a0, a1, lim;
    assign zr  = $signed({cz_s[K][l][31], cz_s[K][l]}) + RND;
    assign a0  = zr >>> SH;
    assign a1  = dn_s[K][l] ? -a0 : a0;
    assign lim = $signed({{(33-icr4ws_pkg::LIM_W){1'b0}}, steer_limit_i});
    assign ang[l] = (a1 > lim) ? lim[AW-1:0] : ((a1 < -lim) ? AW'(-lim) : a1[AW-1:0]);
    assign rnum[l] = {root_s[K][l], {FRAC_BITS{1'b0}}};
    assign rden[l] = {ctl_s[K].rm, 1'b0};
    assign rrem[l] = '0;
  end

  assign rsb_in = '{valid: ctl_s[K].valid, stop: ctl_s[K].stop, vneg: ctl_s[K].vneg,
                    vmag: ctl_s[K].vmag, ang_l: ang[0], ang_r: ang[1]};

  icr4ws_div #(
    .N_W  (RW),
    .DEN_W(RM_W_P + 1),
    .LANES(2),
    .SB_W ($bits(rsb_t))
  ) u_ratio_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .num_i (rnum),
    .den_i (rden),
    .rem_i (rrem),
    .sb_i  (rsb_in),
    .q_o   (ratio),
    .sb_o  (rsb_out)
  );

  // Partial products of |v| * ratio, then the sum and the saturation test.
  rsb_t                 rsb_p_q;
  logic [VW+H-1:0]      plo_q [2];
  logic [VW+HI_W-1:0]   phi_q [2];
  logic [icr4ws_pkg::WRAD_W-1:0] wrad;
  logic [31:0]          snum [2];
  logic [icr4ws_pkg::WRAD_W-1:0] sden [2];
  logic [icr4ws_pkg::WRAD_W-1:0] srem [2];
  logic                 big [2];
  logic [31:0]          quo [2];
  ssb_t                 ssb_in, ssb_out;

  assign wrad = (wheel_radius_i == '0) ? icr4ws_pkg::WRAD_W'(1) : wheel_radius_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsb_p_q <= '0;
    end else if (en_i) begin
      rsb_p_q <= rsb_out;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_prod
    logic [PW-1:0]    psum;
    logic [EXT_W-1:0] pext;
    logic [63:0]      p64;
    logic             ovf;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[l] <= (VW+H)'(rsb_out.vmag) * (VW+H)'(ratio[l][H-1:0]);
        phi_q[l] <= (VW+HI_W)'(rsb_out.vmag) * (VW+HI_W)'(ratio[l][RW-1:H]);
      end
    end
    assign psum = PW'(plo_q[l]) + (PW'(phi_q[l]) << H);
    assign pext = EXT_W'(psum);
    assign ovf  = |pext[EXT_W-1:64];
    assign p64  = ovf ? '1 : pext[63:0];
    assign big[l]  = ovf || (p64[63:32] >= 32'(wrad));
    assign snum[l] = p64[31:0];
    assign srem[l] = p64[32+icr4ws_pkg::WRAD_W-1:32];
    assign sden[l] = wrad;
  end

  assign ssb_in = '{valid: rsb_p_q.valid, stop: rsb_p_q.stop, vneg: rsb_p_q.vneg,
                    big_l: big[0], big_r: big[1], ang_l: rsb_p_q.ang_l, ang_r: rsb_p_q.ang_r};

  icr4ws_div #(
    .N_W  (32),
    .DEN_W(icr4ws_pkg::WRAD_W),
    .LANES(2),
    .SB_W ($bits(ssb_t))
  ) u_speed_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en_i),
    .num_i (snum),
    .den_i (sden),
    .rem_i (srem),
    .sb_i  (ssb_in),
    .q_o   (quo),
    .sb_o  (ssb_out)
  );

  // Sign and saturation of the wheel speeds.
  logic [31:0] spd [2];
  logic        sbig [2];
  assign sbig[0] = ssb_out.big_l;
  assign sbig[1] = ssb_out.big_r;

  for (genvar l = 0; l < 2; l++) begin : g_sat
    always_comb begin
      if (ssb_out.stop) begin
        spd[l] = '0;
      end else if (!ssb_out.vneg) begin
        spd[l] = (sbig[l] || quo[l][31]) ? 32'h7FFF_FFFF : quo[l];
      end else begin
        spd[l] = (sbig[l] || (quo[l] > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-quo[l]);
      end
    end
  end

  assign res_o.valid   = ssb_out.valid;
  assign res_o.stop    = ssb_out.stop;
  assign res_o.steer_l = ssb_out.stop ? '0 : ssb_out.ang_l;
  assign res_o.steer_r = ssb_out.stop ? '0 : ssb_out.ang_r;
  assign res_o.speed_l = spd[0];
  assign res_o.speed_r = spd[1];

endmodule
`default_nettype wire

// ----- src/icr_four_wheel_steer_map_unit.sv -----
// Channel   Dir  Handshake        Content
// s_axis    in   tvalid/tready    tdata: forward_speed, yaw_rate
// m_axis    out  tvalid/tready    tdata: eight wheel values, tuser: stopped
// cfg       in   cfg_we_i         cfg_idx_i selects the register, cfg_data_i
//
// A command enters every cycle while the spare entry of the output buffer is empty.
// Each command passes through the three restoring dividers, one quotient bit per stage, and the 32-step root.
// Reset empties the pipeline and loads the register defaults.
// A stalled output parks words in a two-entry output buffer; the pipeline
// halts only when both entries are full.
`default_nettype none
module icr_four_wheel_steer_map_unit #(
  parameter int unsigned FRAC_BITS     = icr4ws_pkg::FRAC_BITS,
  parameter int unsigned CORDIC_STAGES = icr4ws_pkg::CORDIC_STAGES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [icr4ws_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [icr4ws_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // forward_speed, yaw_rate, zero fill
  input  logic [47:0]                     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // steer fl, fr, rl, rr, speed fl, fr, rl, rr
  output logic [199:0]                    m_axis_tdata,
  // stopped
  output logic                            m_axis_tuser
);

  localparam int unsigned IN_W = icr4ws_pkg::IN_W;
  localparam int unsigned NUM_W = 20 + FRAC_BITS;

  typedef struct packed {
    logic            valid;
    logic            stop;
    logic            vneg;
    logic            wneg;
    logic [IN_W-1:0] vmag;
  } rad_sb_t;

  logic [icr4ws_pkg::BASE_W-1:0]  base_q;
  logic [icr4ws_pkg::TRACK_W-1:0] track_q;
  logic [icr4ws_pkg::WRAD_W-1:0]  wrad_q;
  logic [icr4ws_pkg::LIM_W-1:0]   lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= icr4ws_pkg::BASE_RST;
      track_q <= icr4ws_pkg::TRACK_RST;
      wrad_q  <= icr4ws_pkg::WRAD_RST;
      lim_q   <= icr4ws_pkg::LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        icr4ws_pkg::REG_WHEEL_BASE:   base_q  <= cfg_data_i;
        icr4ws_pkg::REG_WHEEL_TRACK:  track_q <= cfg_data_i;
        icr4ws_pkg::REG_WHEEL_RADIUS: wrad_q  <= cfg_data_i[icr4ws_pkg::WRAD_W-1:0];
        icr4ws_pkg::REG_STEER_LIMIT:  lim_q   <= cfg_data_i[icr4ws_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic head_vld_q, spare_vld_q;

  assign en            = !spare_vld_q;
  assign s_axis_tready = en;

  // Input register.
  logic                   in_vld_q;
  logic signed [IN_W-1:0] v_q, w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q <= $signed(s_axis_tdata[IN_W-1:0]);
      w_q <= $signed(s_axis_tdata[2*IN_W-1:IN_W]);
    end
  end

  // Radius magnitude |R| = (v' << FRAC_BITS) / |w'|.
  logic [19:0]      vc;
  logic [IN_W-1:0]  wabs, wm;
  logic [NUM_W-1:0] rnum [1];
  logic [IN_W-1:0]  rden [1];
  logic [IN_W-1:0]  rrem [1];
  logic [NUM_W-1:0] rq   [1];
  rad_sb_t          rsb_in, rsb_out;

  assign vc   = (v_q < 1) ? 20'd1 : v_q[19:0];
  assign wabs = w_q[IN_W-1] ? IN_W'(-w_q) : w_q;
  assign wm   = (wabs == '0) ? IN_W'(1) : wabs;
  assign rnum[0] = {vc, {FRAC_BITS{1'b0}}};
  assign rden[0] = wm;
  assign rrem[0] = '0;
  assign rsb_in = '{valid: in_vld_q, stop: (v_q == '0) && (w_q == '0), vneg: v_q[IN_W-1],
                    wneg: w_q[IN_W-1], vmag: v_q[IN_W-1] ? IN_W'(-v_q) : v_q};

  icr4ws_div #(
    .N_W  (NUM_W),
    .DEN_W(IN_W),
    .LANES(1),
    .SB_W ($bits(rad_sb_t))
  ) u_radius_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .num_i (rnum),
    .den_i (rden),
    .rem_i (rrem),
    .sb_i  (rsb_in),
    .q_o   (rq),
    .sb_o  (rsb_out)
  );

  // Radius clamp and the signed distances 2R - track and 2R + track.
  logic [63:0]                          qext;
  logic [icr4ws_pkg::RM_W-1:0]          rmc;
  logic signed [icr4ws_pkg::D_W-1:0]    r2, trk;
  icr4ws_pkg::ctl_t                     ctl_q;
  logic signed [icr4ws_pkg::D_W-1:0]    d_q [2];

  assign qext = 64'(rq[0]);
  assign rmc  = (qext == '0) ? icr4ws_pkg::RM_W'(1) :
                ((qext > 64'h3FFF_FFFF) ? '1 : qext[icr4ws_pkg::RM_W-1:0]);
  assign r2   = rsb_out.wneg ? -$signed({2'b00, rmc, 1'b0}) : $signed({2'b00, rmc, 1'b0});
  assign trk  = $signed({{(icr4ws_pkg::D_W-icr4ws_pkg::TRACK_W){1'b0}}, track_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en) begin
      ctl_q <= '{valid: rsb_out.valid, stop: rsb_out.stop, vneg: rsb_out.vneg,
                 vmag: rsb_out.vmag, rm: rmc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0] <= r2 - trk;
      d_q[1] <= r2 + trk;
    end
  end

  icr4ws_pkg::res_t res;

  icr4ws_lanes #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_lanes (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .wheel_base_i  (base_q),
    .wheel_radius_i(wrad_q),
    .steer_limit_i (lim_q),
    .ctl_i         (ctl_q),
    .d_i           (d_q),
    .res_o         (res)
  );

  // Output buffer: head drives the port, spare catches a word during a stall.
  logic [199:0] new_data, head_data_q, spare_data_q;
  logic         head_user_q, spare_user_q;
  logic         push, pop;

  assign new_data = {res.speed_r, res.speed_l, res.speed_r, res.speed_l,
                     icr4ws_pkg::ANG_W'(-res.steer_r), icr4ws_pkg::ANG_W'(-res.steer_l),
                     res.steer_r, res.steer_l};
  assign push = en && res.valid;
  assign pop  = head_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= 1'b0;
      spare_vld_q <= 1'b0;
    end else if (spare_vld_q) begin
      if (pop) begin
        spare_vld_q <= 1'b0;
      end
    end else if (push && head_vld_q && !pop) begin
      spare_vld_q <= 1'b1;
    end else if (push) begin
      head_vld_q <= 1'b1;
    end else if (pop) begin
      head_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_vld_q) begin
      if (pop) begin
        head_data_q <= spare_data_q;
        head_user_q <= spare_user_q;
      end
    end else if (push && head_vld_q && !pop) begin
      spare_data_q <= new_data;
      spare_user_q <= res.stop;
    end else if (push) begin
      head_data_q <= new_data;
      head_user_q <= res.stop;
    end
  end

  assign m_axis_tvalid = head_vld_q;
  assign m_axis_tdata  = head_data_q;
  assign m_axis_tuser  = head_user_q;

endmodule
`default_nettype wire

// ----- src/icr4ws_checker.sv -----
`default_nettype none
`include "icr_four_wheel_steer_map_unit_defines.svh"
module icr4ws_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  `ICR4WS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled word changed.")
  `ICR4WS_ASSERT(a_stop_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "Stop word is not zero.")
  `ICR4WS_ASSERT(a_rear_steer, m_axis_tvalid, ((m_axis_tdata[53:36] + m_axis_tdata[17:0]) == 18'd0) && ((m_axis_tdata[71:54] + m_axis_tdata[35:18]) == 18'd0), "Rear angle is not the negated front angle.")
  `ICR4WS_ASSERT(a_rear_speed, m_axis_tvalid, (m_axis_tdata[167:136] == m_axis_tdata[103:72]) && (m_axis_tdata[199:168] == m_axis_tdata[135:104]), "Rear speed differs from front speed.")
  `ICR4WS_ASSERT(a_full_buf, !s_axis_tready, m_axis_tvalid, "Input stalled with no word waiting.")

endmodule

bind icr_four_wheel_steer_map_unit icr4ws_checker u_icr4ws_checker (.*);
`default_nettype wire
